// ----- hdl/joint_setpoint_ramp_watchdog_core_defines.svh -----
// Assertion macros used by the checker file of the ramp watchdog core.
`ifndef JOINT_SETPOINT_RAMP_WATCHDOG_CORE_DEFINES_SVH
`define JOINT_SETPOINT_RAMP_WATCHDOG_CORE_DEFINES_SVH

// Same-cycle implication, checked only out of reset.
`define JSRW_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked only out of reset.
`define JSRW_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/jsrw_pkg.sv -----
// Package: payload types, codes and constants of the ramp watchdog core.
`timescale 1ns / 1ps
`default_nettype none

package jsrw_pkg;

    // Action codes
    localparam logic [2:0] ACT_TICK      = 3'd0;
    localparam logic [2:0] ACT_ARM       = 3'd1;
    localparam logic [2:0] ACT_RESEED    = 3'd2;
    localparam logic [2:0] ACT_DISARM    = 3'd3;
    localparam logic [2:0] ACT_CYCLE_END = 3'd4;

    // Configuration register indexes
    localparam logic [1:0] CFG_MAX_STEP     = 2'd0;
    localparam logic [1:0] CFG_RAMP_BYPASS  = 2'd1;
    localparam logic [1:0] CFG_TICK_RATE_HZ = 2'd2;

    localparam logic [30:0] MAX_STEP_RESET  = 31'd0;
    localparam logic        BYPASS_RESET    = 1'b1;
    localparam logic [13:0] TICK_RATE_RESET = 14'd200;

    // Watchdog thresholds
    localparam logic [6:0] STALE_MARK   = 7'd20;
    localparam logic [6:0] STALE_KILL   = 7'd100;
    localparam logic [6:0] STALE_MAX    = 7'd127;
    localparam logic [5:0] SILENT_LIMIT = 6'd50;

    localparam logic signed [31:0] VEL_POS_SAT = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] VEL_NEG_SAT = 32'sh8000_0000;

    typedef struct packed {
        logic [2:0]         action;
        logic [3:0]         motor_index;
        logic signed [31:0] target_angle;
        logic signed [31:0] target_velocity;
        logic               feedback_fresh;
        logic [7:0]         fault_code;
        logic signed [31:0] measured_angle;
        logic               drop_fault;
    } in_item_t;

    typedef struct packed {
        logic               command_valid;
        logic signed [31:0] command_angle;
        logic signed [31:0] command_velocity;
        logic               is_enabled;
        logic               is_stale;
        logic               is_faulted;
        logic               recover_request;
    } out_item_t;

    // One slot word in the slot RAM
    typedef struct packed {
        logic [6:0]         stale_count;
        logic signed [31:0] ramp_angle;
    } slot_word_t;

    typedef struct packed {
        logic load;
        logic read;
        logic step;
        logic finish;
    } jsrw_cmd_t;

    typedef struct packed {
        logic out_busy;
        logic out_full;
    } jsrw_sts_t;

endpackage

`default_nettype wire

// ----- hdl/joint_setpoint_ramp_watchdog_core.sv -----
// Top level of the per-joint setpoint ramp and feedback watchdog core.
//
//   channel  | direction | handshake                 | payload
//   ---------+-----------+---------------------------+-------------------------
//   item     | in        | item_valid / item_stall   | in_item_t
//   result   | out       | result_valid / result_stall | out_item_t
//   cfg      | in        | cfg_valid / cfg_ready     | cfg_index, cfg_data
//
// One transaction in flight: accept, slot RAM read, ramp step, then multiply,
// state write-back and result load. The slot RAM read is registered, and the
// velocity multiply is combinational in the finish stage.
// Reset clears all slot flags, stale count valid bits and counters, and loads config defaults.
// A stalled result holds the finish stage; the next transaction is taken on
// the same edge the pending result leaves the output register.
`timescale 1ns / 1ps
`default_nettype none

module joint_setpoint_ramp_watchdog_core
    import jsrw_pkg::*;
#(
    parameter int MOTOR_SLOTS = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // input transactions
    input  wire logic        item_valid,
    output logic             item_stall,
    input  wire in_item_t    item,
    // result transactions
    output logic             result_valid,
    input  wire logic        result_stall,
    output out_item_t        result,
    // configuration writes, always ready
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [30:0] cfg_data
);

    jsrw_cmd_t cmd;
    jsrw_sts_t sts;

    // Sequencer: owns the item-side handshake
    jsrw_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .sts        (sts),
        .cmd        (cmd)
    );

    // Datapath: slot state, ramp arithmetic, output register
    jsrw_datapath #(
        .MOTOR_SLOTS (MOTOR_SLOTS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .cmd          (cmd),
        .sts          (sts),
        .result_stall (result_stall),
        .result_valid (result_valid),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

endmodule

`default_nettype wire

// ----- hdl/jsrw_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module jsrw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]  wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem_reg[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ----- hdl/jsrw_ctrl.sv -----
// Controller: sequences one transaction through read, step and finish.
`timescale 1ns / 1ps
`default_nettype none

module jsrw_ctrl
    import jsrw_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      item_valid,
    output logic           item_stall,
    input  wire jsrw_sts_t sts,
    output jsrw_cmd_t      cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_STEP,
        S_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   take;

    always_comb
    begin
        take = (state_reg == S_IDLE) || ((state_reg == S_FINISH) && !sts.out_busy);
        item_stall = !take;
        cmd.load   = item_valid && take;
        cmd.read   = (state_reg == S_READ);
        cmd.step   = (state_reg == S_STEP);
        cmd.finish = (state_reg == S_FINISH) && !sts.out_busy;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    state_next = S_READ;
                end
            end
            S_READ:   state_next = S_STEP;
            S_STEP:   state_next = S_FINISH;
            S_FINISH:
            begin
                if (!sts.out_busy)
                begin
                    state_next = item_valid ? S_READ : S_IDLE;
                end
            end
            default:  state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/jsrw_datapath.sv -----
// Datapath: config registers, slot flags, slot RAM, ramp step and velocity.
`timescale 1ns / 1ps
`default_nettype none

module jsrw_datapath
    import jsrw_pkg::*;
#(
    parameter int MOTOR_SLOTS = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire in_item_t    item,
    input  wire jsrw_cmd_t   cmd,
    output jsrw_sts_t        sts,
    input  wire logic        result_stall,
    output logic             result_valid,
    output out_item_t        result,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [30:0] cfg_data
);

    localparam int ADDR_W  = (MOTOR_SLOTS > 1) ? $clog2(MOTOR_SLOTS) : 1;
    localparam int TOTAL_W = $clog2(MOTOR_SLOTS + 1);
    localparam int WORD_W  = $bits(slot_word_t);

    // Configuration
    logic [30:0] max_step_reg;
    logic        bypass_reg;
    logic [13:0] tick_rate_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_step_reg  <= MAX_STEP_RESET;
            bypass_reg    <= BYPASS_RESET;
            tick_rate_reg <= TICK_RATE_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_MAX_STEP:     max_step_reg  <= cfg_data;
                CFG_RAMP_BYPASS:  bypass_reg    <= cfg_data[0];
                CFG_TICK_RATE_HZ: tick_rate_reg <= cfg_data[13:0];
                default:          ;
            endcase
        end
    end

    // Item capture
    in_item_t          item_reg;
    logic              slot_ok;
    logic [ADDR_W-1:0] addr;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg <= item;
        end
    end

    assign slot_ok = ({28'd0, item_reg.motor_index} < 32'(MOTOR_SLOTS));
    assign addr    = ADDR_W'(item_reg.motor_index);

    // Slot RAM: ramp angle and stale count; count valid bits clear on reset
    logic [MOTOR_SLOTS-1:0] cnt_valid_reg;
    logic [MOTOR_SLOTS-1:0] enabled_reg;
    logic [MOTOR_SLOTS-1:0] faulted_reg;
    logic [MOTOR_SLOTS-1:0] stale_reg;
    logic [TOTAL_W-1:0]     total_reg;
    logic [5:0]             silent_reg;
    slot_word_t             rd_word;
    slot_word_t             wr_word;
    logic                   wr_en;
    logic [WORD_W-1:0]      rd_raw;

    jsrw_ram #(
        .WIDTH (WORD_W),
        .DEPTH (MOTOR_SLOTS)
    ) u_slot_ram (
        .clk     (clk),
        .wr_en   (cmd.finish && wr_en),
        .wr_addr (addr),
        .wr_data (wr_word),
        .rd_en   (cmd.read),
        .rd_addr (addr),
        .rd_data (rd_raw)
    );

    assign rd_word = slot_word_t'(rd_raw);

    // Ramp step stage
    logic signed [32:0] err;
    logic signed [32:0] step_pos;
    logic signed [32:0] step_neg;
    logic signed [31:0] diff;
    logic signed [31:0] diff_reg;
    logic signed [31:0] new_angle_reg;
    logic signed [31:0] old_angle_reg;
    logic [6:0]         cnt_old_reg;

    always_comb
    begin
        err      = {item_reg.target_angle[31], item_reg.target_angle}
                 - {rd_word.ramp_angle[31], rd_word.ramp_angle};
        step_pos = {2'b00, max_step_reg};
        step_neg = -step_pos;
        if (err > step_pos)
        begin
            diff = step_pos[31:0];
        end
        else if (err < step_neg)
        begin
            diff = step_neg[31:0];
        end
        else
        begin
            diff = err[31:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.step)
        begin
            diff_reg      <= diff;
            new_angle_reg <= rd_word.ramp_angle + diff;
            old_angle_reg <= rd_word.ramp_angle;
            cnt_old_reg   <= (slot_ok && cnt_valid_reg[addr]) ? rd_word.stale_count : 7'd0;
        end
    end

    // Finish stage: velocity, watchdog, flag and RAM update
    logic signed [46:0] prod;
    logic signed [31:0] vel_sat;
    logic               en_old;
    logic               flt_old;
    logic               stl_old;
    logic               en_new;
    logic               flt_new;
    logic               stl_new;
    logic [6:0]         cnt_new;
    logic signed [31:0] ang_new;
    logic [5:0]         silent_new;
    logic               fresh;
    out_item_t          res;

    always_comb
    begin
        prod = diff_reg * $signed({1'b0, tick_rate_reg});
        if (prod[46:31] != {16{prod[46]}})
        begin
            vel_sat = prod[46] ? VEL_NEG_SAT : VEL_POS_SAT;
        end
        else
        begin
            vel_sat = prod[31:0];
        end
    end

    always_comb
    begin
        fresh      = item_reg.feedback_fresh;
        en_old     = slot_ok && enabled_reg[addr];
        flt_old    = slot_ok && faulted_reg[addr];
        stl_old    = slot_ok && stale_reg[addr];
        en_new     = en_old;
        flt_new    = flt_old;
        stl_new    = stl_old;
        cnt_new    = cnt_old_reg;
        ang_new    = old_angle_reg;
        silent_new = silent_reg;
        wr_en      = 1'b0;
        res        = '0;
        unique case (item_reg.action)
            ACT_TICK:
            begin
                if (en_old)
                begin
                    res.command_valid = 1'b1;
                    wr_en = 1'b1;
                    if (bypass_reg)
                    begin
                        res.command_angle    = item_reg.target_angle;
                        res.command_velocity = item_reg.target_velocity;
                    end
                    else
                    begin
                        res.command_angle    = new_angle_reg;
                        res.command_velocity = vel_sat;
                        ang_new              = new_angle_reg;
                    end
                    if (fresh && (item_reg.fault_code != 8'd0))
                    begin
                        flt_new = 1'b1;
                        en_new  = 1'b0;
                    end
                    else
                    begin
                        if (fresh)
                        begin
                            cnt_new = 7'd0;
                            stl_new = 1'b0;
                        end
                        else if (cnt_old_reg < STALE_MAX)
                        begin
                            cnt_new = cnt_old_reg + 7'd1;
                        end
                        if (cnt_new >= STALE_MARK)
                        begin
                            stl_new = 1'b1;
                        end
                        if (cnt_new >= STALE_KILL)
                        begin
                            en_new  = 1'b0;
                            flt_new = 1'b1;
                        end
                    end
                end
            end
            ACT_ARM:
            begin
                if (slot_ok)
                begin
                    ang_new = item_reg.measured_angle;
                    wr_en   = 1'b1;
                    en_new  = 1'b1;
                end
            end
            ACT_RESEED:
            begin
                if (slot_ok)
                begin
                    ang_new = item_reg.measured_angle;
                    wr_en   = 1'b1;
                end
            end
            ACT_DISARM:
            begin
                if (slot_ok)
                begin
                    en_new = 1'b0;
                    if (item_reg.drop_fault)
                    begin
                        flt_new = 1'b0;
                    end
                end
            end
            ACT_CYCLE_END:
            begin
                if ((total_reg != '0) && !fresh)
                begin
                    if (silent_reg == SILENT_LIMIT - 6'd1)
                    begin
                        res.recover_request = 1'b1;
                        silent_new = 6'd0;
                    end
                    else
                    begin
                        silent_new = silent_reg + 6'd1;
                    end
                end
                else
                begin
                    silent_new = 6'd0;
                end
            end
            default: ;
        endcase
        res.is_enabled = en_new;
        res.is_stale   = stl_new;
        res.is_faulted = flt_new;
        wr_word.stale_count = cnt_new;
        wr_word.ramp_angle  = ang_new;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_valid_reg <= '0;
            enabled_reg   <= '0;
            faulted_reg   <= '0;
            stale_reg     <= '0;
            total_reg     <= '0;
            silent_reg    <= 6'd0;
            result_valid  <= 1'b0;
        end
        else
        begin
            if (cmd.finish)
            begin
                if (slot_ok)
                begin
                    enabled_reg[addr] <= en_new;
                    faulted_reg[addr] <= flt_new;
                    stale_reg[addr]   <= stl_new;
                    if (wr_en)
                    begin
                        cnt_valid_reg[addr] <= 1'b1;
                    end
                end
                if (en_new && !en_old)
                begin
                    total_reg <= total_reg + TOTAL_W'(1);
                end
                else if (!en_new && en_old)
                begin
                    total_reg <= total_reg - TOTAL_W'(1);
                end
                silent_reg   <= silent_new;
                result_valid <= 1'b1;
            end
            else if (!result_stall)
            begin
                result_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            result <= res;
        end
    end

    assign sts.out_busy = result_valid && result_stall;
    assign sts.out_full = result_valid;

endmodule

`default_nettype wire

// ----- hdl/jsrw_checker.sv -----
// Port-level checker for the ramp watchdog core, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "joint_setpoint_ramp_watchdog_core_defines.svh"

module jsrw_checker
    import jsrw_pkg::*;
(
    input wire logic      clk,
    input wire logic      rst_n,
    input wire logic      item_valid,
    input wire logic      item_stall,
    input wire logic      result_valid,
    input wire logic      result_stall,
    input wire out_item_t result
);

    `JSRW_ASSERT_NEXT(a_result_hold, clk, rst_n, result_valid && result_stall, result_valid && $stable(result), "stalled result changed")
    `JSRW_ASSERT_NEXT(a_one_in_flight, clk, rst_n, item_valid && !item_stall, item_stall, "second transaction taken while one is in flight")
    `JSRW_ASSERT_NOW(a_idle_cmd_zero, clk, rst_n, result_valid && !result.command_valid, (result.command_angle == 32'sd0) && (result.command_velocity == 32'sd0), "command fields nonzero without a command")
    `JSRW_ASSERT_NOW(a_recover_excl, clk, rst_n, result_valid && result.recover_request, !result.command_valid, "recovery request on a command result")

endmodule

bind joint_setpoint_ramp_watchdog_core jsrw_checker u_jsrw_checker (.*);

`default_nettype wire
